>>> rtl/core/xs128p_pkg.sv
// ----------------------------------------------------------------------------
// xs128p_pkg
// Shared types and constants for the xorshift128+ generator core.
// ----------------------------------------------------------------------------
package xs128p_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned OpW   = 2;
  localparam int unsigned FracW = 53;

  localparam logic [WordW-1:0] GoldenGamma = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMulA     = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMulB     = 64'h94d049bb133111eb;

  localparam int unsigned MixShift0 = 30;
  localparam int unsigned MixShift1 = 27;
  localparam int unsigned MixShift2 = 31;
  localparam int unsigned XsShiftA  = 23;
  localparam int unsigned XsShiftB  = 18;
  localparam int unsigned XsShiftC  = 5;

  typedef enum logic [OpW-1:0] {
    OP_SEED_LOW  = 2'd0,
    OP_SEED_HIGH = 2'd1,
    OP_DRAW      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  // Which 32x32 partial product the shared multiplier forms this cycle
  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_step_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_MA0  = 4'd1,
    ST_MA1  = 4'd2,
    ST_MA2  = 4'd3,
    ST_FOLD = 4'd4,
    ST_MB0  = 4'd5,
    ST_MB1  = 4'd6,
    ST_MB2  = 4'd7,
    ST_FIN  = 4'd8
  } state_t;

  typedef struct packed {
    logic      seed_load;
    logic      mul_en;
    mul_step_t step;
    logic      mul_b;
    logic      fold;
    logic      commit;
    logic      emit;
    logic      draw;
  } dp_cmd_t;

endpackage

>>> rtl/core/xs128p_if.sv
// ----------------------------------------------------------------------------
// xs128p_req_if / xs128p_rsp_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface xs128p_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] seed_word;

  modport source (output valid, output op, output seed_word, input ready);
  modport sink   (input valid, input op, input seed_word, output ready);
endinterface

interface xs128p_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [52:0] fraction;

  modport source (output valid, output value, output fraction, input ready);
  modport sink   (input valid, input value, input fraction, output ready);
endinterface

>>> rtl/core/xorshift128plus_generator_core.sv
// ----------------------------------------------------------------------------
// xorshift128plus_generator_core
// xorshift128+ generator with splitmix64 seeding of its two state words.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                          transfer
//   -------  ---  -------------------------------  -----------------
//   req      in   op[1:0], seed_word[63:0]         valid && ready
//   rsp      out  value[63:0], fraction[52:0]      valid && ready
//
// Sequence: a draw (or an unused op code) writes the result register when
//   taken; a new request is taken every cycle while the result is consumed.
//   A seed word gets the gamma add, a 64-bit multiply on the shared 32x32
//   multiplier (three partial products), a fold, a second multiply, a load.
// Reset: both state words clear to zero; draws return zero until seeded.
// Stalls: the result register holds one word; req.ready stays high while it
//   is being taken, and drops while it is held or the mixer is busy.
//
module xorshift128plus_generator_core (
  input  logic         clk,
  input  logic         rst,
  xs128p_req_if.sink   req,
  xs128p_rsp_if.source rsp
);
  import xs128p_pkg::*;

  dp_cmd_t     cmd;
  logic [63:0] value;

  // Sequencer: hold requests while the mixer runs, own the result valid
  xs128p_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .op        (req.op),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd)
  );

  // Datapath: state words, draw step, mixer, result word register
  xs128p_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .op        (req.op),
    .seed_word (req.seed_word),
    .value     (value)
  );

  // Fraction is the low 53 bits of the result word, scaled by 2^-53
  assign rsp.value    = value;
  assign rsp.fraction = value[FracW-1:0];

endmodule

>>> rtl/core/xs128p_ctrl.sv
// ----------------------------------------------------------------------------
// xs128p_ctrl
// Sequencer for the seed mixer and owner of the result word valid flag.
// ----------------------------------------------------------------------------
module xs128p_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          op,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output xs128p_pkg::dp_cmd_t cmd
);
  import xs128p_pkg::*;

  state_t state, state_next;
  logic   accept;
  logic   is_seed;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign is_seed  = (op_t'(op) == OP_SEED_LOW) || (op_t'(op) == OP_SEED_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.step   = MUL_LL;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_seed) begin
            cmd.seed_load = 1'b1;
            state_next    = ST_MA0;
          end else begin
            // draw, or unused code which returns zero
            cmd.emit = 1'b1;
            cmd.draw = (op_t'(op) == OP_DRAW);
          end
        end
      end
      ST_MA0: begin
        cmd.mul_en = 1'b1;
        cmd.step   = MUL_LL;
        state_next = ST_MA1;
      end
      ST_MA1: begin
        cmd.mul_en = 1'b1;
        cmd.step   = MUL_LH;
        state_next = ST_MA2;
      end
      ST_MA2: begin
        cmd.mul_en = 1'b1;
        cmd.step   = MUL_HL;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_MB0;
      end
      ST_MB0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_b  = 1'b1;
        cmd.step   = MUL_LL;
        state_next = ST_MB1;
      end
      ST_MB1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_b  = 1'b1;
        cmd.step   = MUL_LH;
        state_next = ST_MB2;
      end
      ST_MB2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_b  = 1'b1;
        cmd.step   = MUL_HL;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.commit = 1'b1;
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_seed_starts_mix: assert property (@(posedge clk) disable iff (rst)
    accept && is_seed |=> state == ST_MA0)
    else $error("seed word did not start the mixer");

  a_fin_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN |-> !out_valid)
    else $error("result slot occupied at end of seeding");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result word overwritten while stalled");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready)
    else $error("input taken while mixer busy");

endmodule

>>> rtl/core/xs128p_dp.sv
// ----------------------------------------------------------------------------
// xs128p_dp
// State words, xorshift128+ step, splitmix64 mixer with one shared
// 32x32 multiplier, and the result word register.
// ----------------------------------------------------------------------------
module xs128p_dp (
  input  logic                clk,
  input  logic                rst,
  input  xs128p_pkg::dp_cmd_t cmd,
  input  logic [1:0]          op,
  input  logic [63:0]         seed_word,
  output logic [63:0]         value
);
  import xs128p_pkg::*;

  logic [WordW-1:0] word_low;
  logic [WordW-1:0] word_high;
  logic [WordW-1:0] z;
  logic [WordW-1:0] acc;
  logic             target;

  logic [WordW-1:0] seed_sum;
  logic [WordW-1:0] mul_const;
  logic [HalfW-1:0] mul_x;
  logic [HalfW-1:0] mul_y;
  logic [WordW-1:0] prod;
  logic [WordW-1:0] acc_next;
  logic [WordW-1:0] mixed;

  logic [WordW-1:0] xs_sum;
  logic [WordW-1:0] xs_a1;
  logic [WordW-1:0] xs_a2;
  logic [WordW-1:0] xs_new_high;
  logic [WordW-1:0] draw_value;

  assign seed_sum  = seed_word + GoldenGamma;
  assign mul_const = cmd.mul_b ? MixMulB : MixMulA;

  // Low 64 bits of z * const from three 32x32 partial products
  always_comb begin
    mul_x = z[HalfW-1:0];
    mul_y = mul_const[HalfW-1:0];
    case (cmd.step)
      MUL_LL: begin
        mul_x = z[HalfW-1:0];
        mul_y = mul_const[HalfW-1:0];
      end
      MUL_LH: begin
        mul_x = z[HalfW-1:0];
        mul_y = mul_const[WordW-1:HalfW];
      end
      MUL_HL: begin
        mul_x = z[WordW-1:HalfW];
        mul_y = mul_const[HalfW-1:0];
      end
      default: begin
        mul_x = z[HalfW-1:0];
        mul_y = mul_const[HalfW-1:0];
      end
    endcase
  end

  assign prod     = WordW'(mul_x) * WordW'(mul_y);
  assign acc_next = (cmd.step == MUL_LL) ? prod : acc + {prod[HalfW-1:0], {HalfW{1'b0}}};
  assign mixed    = acc ^ (acc >> MixShift2);

  // xorshift128+ step
  assign xs_sum      = word_low + word_high;
  assign xs_a1       = word_low ^ (word_low << XsShiftA);
  assign xs_a2       = xs_a1 ^ (xs_a1 >> XsShiftB);
  assign xs_new_high = xs_a2 ^ word_high ^ (word_high >> XsShiftC);
  assign draw_value  = xs_sum + xs_new_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_low  <= '0;
      word_high <= '0;
    end else if (cmd.draw) begin
      word_low  <= word_high;
      word_high <= xs_new_high;
    end else if (cmd.commit) begin
      if (target) begin
        word_high <= mixed;
      end else begin
        word_low <= mixed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      z      <= seed_sum ^ (seed_sum >> MixShift0);
      target <= (op_t'(op) == OP_SEED_HIGH);
    end else if (cmd.fold) begin
      z <= acc ^ (acc >> MixShift1);
    end
    if (cmd.mul_en) begin
      acc <= acc_next;
    end
    if (cmd.emit) begin
      value <= cmd.draw ? draw_value : '0;
    end
  end

  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.draw && word_low == '0 && word_high == '0 |=> value == '0)
    else $error("unseeded draw gave a non-zero word");

  a_draw_shifts_state: assert property (@(posedge clk) disable iff (rst)
    cmd.draw |=> word_low == $past(word_high))
    else $error("draw did not move high word into low word");

  a_seed_value_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> value == '0)
    else $error("seed result word is not zero");

endmodule
